// ===== rtl/core/sscr_pkg.sv =====
// Shared types, constants and helper functions of the seven-segment rectangle renderer.
package sscr_pkg;

  localparam int NumDigits = 6;
  localparam int DigitW    = 4;
  localparam int DigIdxW   = 3;
  localparam int ValW      = 7;
  localparam int CoordW    = 12;
  localparam int ColorW    = 16;
  localparam int SizeW     = 8;
  localparam int LineW     = 6;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int SlotCount = 8;

  localparam logic [DigitW-1:0] DigitBlank = 4'd15;

  localparam logic [SizeW-1:0]  MarginRst    = 8'd20;
  localparam logic [SizeW-1:0]  DigitGapRst  = 8'd5;
  localparam logic [SizeW-1:0]  ColonGapRst  = 8'd25;
  localparam logic [SizeW-1:0]  DigitWidRst  = 8'd22;
  localparam logic [LineW-1:0]  LineWidRst   = 6'd2;
  localparam logic [ColorW-1:0] FgColorRst   = 16'hF800;
  localparam logic [ColorW-1:0] BgColorRst   = 16'h0000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMargin   = 3'd0,
    CfgDigitGap = 3'd1,
    CfgColonGap = 3'd2,
    CfgDigitWid = 3'd3,
    CfgLineWid  = 3'd4,
    CfgFgColor  = 3'd5,
    CfgBgColor  = 3'd6
  } cfg_idx_e;

  // One slot per rectangle position within a digit: box clear, then segments
  typedef enum logic [2:0] {
    SlotClear    = 3'd0,
    SlotUpLeft   = 3'd1,
    SlotTop      = 3'd2,
    SlotUpRight  = 3'd3,
    SlotMiddle   = 3'd4,
    SlotLowLeft  = 3'd5,
    SlotBottom   = 3'd6,
    SlotLowRight = 3'd7
  } slot_e;

  typedef struct packed {
    logic [SizeW-1:0]  margin;
    logic [SizeW-1:0]  digit_gap;
    logic [SizeW-1:0]  colon_gap;
    logic [SizeW-1:0]  digit_width;
    logic [LineW-1:0]  line_width;
    logic [ColorW-1:0] fg_color;
    logic [ColorW-1:0] bg_color;
  } cfg_t;

  typedef struct packed {
    logic              busy;
    logic              emit;
    logic              last;
    slot_e             slot;
    logic [CoordW-1:0] x;
  } step_t;

  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
    logic [ColorW-1:0] color;
  } rect_t;

  // Segment pattern, bit 7 upper-left down to bit 1 lower-right; blank above nine
  function automatic logic [7:0] seg_pattern(input logic [DigitW-1:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'hEE;
      4'd1:    p = 8'h22;
      4'd2:    p = 8'h7C;
      4'd3:    p = 8'h76;
      4'd4:    p = 8'hB2;
      4'd5:    p = 8'hD6;
      4'd6:    p = 8'hDE;
      4'd7:    p = 8'h62;
      4'd8:    p = 8'hFE;
      4'd9:    p = 8'hF2;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // Tens digit by reciprocal: v * 205 / 2048 is exact for v below 128
  function automatic logic [DigitW-1:0] div10(input logic [ValW-1:0] v);
    logic [14:0] prod;
    prod = 15'(v) * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [DigitW-1:0] mod10(input logic [ValW-1:0] v);
    logic [DigitW-1:0] t;
    logic [ValW-1:0]   t10;
    t   = div10(v);
    t10 = ValW'({t, 3'b000}) + ValW'({t, 1'b0});
    return DigitW'(v - t10);
  endfunction

endpackage

// ===== rtl/core/sscr_geom.sv =====
// Rectangle corner and colour generation for one slot of one digit box.
module sscr_geom
  import sscr_pkg::*;
(
  input  cfg_t  cfg_i,
  input  step_t step_i,
  output rect_t rect_o
);

  logic [CoordW-1:0] w, w2, lw, hl, x, y;
  logic [CoordW-1:0] x_lw, x_w, x_wl, y_lw, y_w, y_2w, y_2wl, y_mt, y_mb;

  always_comb begin
    w     = CoordW'(cfg_i.digit_width);
    w2    = CoordW'({cfg_i.digit_width, 1'b0});
    lw    = CoordW'(cfg_i.line_width);
    hl    = CoordW'(cfg_i.line_width[LineW-1:1]);
    x     = step_i.x;
    y     = CoordW'(cfg_i.margin);
    x_lw  = x + lw;
    x_w   = x + w;
    x_wl  = x_w - lw;
    y_lw  = y + lw;
    y_w   = y + w;
    y_2w  = y + w2;
    y_2wl = y_2w - lw;
    y_mt  = y_w - hl;
    y_mb  = y_w + hl;

    rect_o.color = cfg_i.fg_color;
    unique case (step_i.slot)
      SlotClear: begin
        rect_o = '{x, y, x_w, y_2w, cfg_i.bg_color};
      end
      SlotUpLeft:   rect_o = '{x,    y,     x_lw, y_w,  cfg_i.fg_color};
      SlotTop:      rect_o = '{x,    y,     x_w,  y_lw, cfg_i.fg_color};
      SlotUpRight:  rect_o = '{x_wl, y,     x_w,  y_w,  cfg_i.fg_color};
      SlotMiddle:   rect_o = '{x,    y_mt,  x_w,  y_mb, cfg_i.fg_color};
      SlotLowLeft:  rect_o = '{x,    y_w,   x_lw, y_2w, cfg_i.fg_color};
      SlotBottom:   rect_o = '{x,    y_2wl, x_w,  y_2w, cfg_i.fg_color};
      SlotLowRight: rect_o = '{x_wl, y_w,   x_w,  y_2w, cfg_i.fg_color};
      default:      rect_o = '{x,    y,     x_w,  y_2w, cfg_i.bg_color};
    endcase
  end

endmodule

// ===== rtl/core/sscr_seq.sv =====
// Digit/slot sequencer: digit split, kept digits, box x accumulator and last-flag logic.
module sscr_seq
  import sscr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ValW-1:0] hours_i,
  input  logic [ValW-1:0] minutes_i,
  input  logic [ValW-1:0] seconds_i,
  input  cfg_t            cfg_i,
  input  logic            adv_i,
  output step_t           step_o
);

  logic                busy_q, busy_d;
  logic [DigIdxW-1:0]  dig_q, dig_d, dig_nxt;
  slot_e               slot_q, slot_d;
  logic [CoordW-1:0]   x_q, x_d;
  logic [NumDigits-1:0] chg_q, chg_d;
  logic [DigitW-1:0]   digits_q [NumDigits];
  logic [DigitW-1:0]   digits_d [NumDigits];
  logic [DigitW-1:0]   shown_q  [NumDigits];
  logic [DigitW-1:0]   new_dig  [NumDigits];
  logic [7:0]          pat, mask;
  logic                more_slot, more_dig, emit;
  logic [SizeW-1:0]    gap;

  always_comb begin
    new_dig[0] = div10(hours_i);
    new_dig[1] = mod10(hours_i);
    new_dig[2] = div10(minutes_i);
    new_dig[3] = mod10(minutes_i);
    new_dig[4] = div10(seconds_i);
    new_dig[5] = mod10(seconds_i);

    pat     = seg_pattern(digits_q[dig_q]);
    mask[0] = 1'b1;
    for (int s = 1; s < SlotCount; s++) begin
      mask[s] = pat[SlotCount - s];
    end
    emit = busy_q && chg_q[dig_q] && mask[slot_q];

    more_slot = 1'b0;
    for (int s = 0; s < SlotCount; s++) begin
      if (s > int'(slot_q) && mask[s]) more_slot = 1'b1;
    end
    more_dig = 1'b0;
    for (int k = 0; k < NumDigits; k++) begin
      if (k > int'(dig_q) && chg_q[k]) more_dig = 1'b1;
    end

    dig_nxt = dig_q + DigIdxW'(1);
    gap     = dig_nxt[0] ? cfg_i.digit_gap : cfg_i.colon_gap;

    busy_d   = busy_q;
    dig_d    = dig_q;
    slot_d   = slot_q;
    x_d      = x_q;
    chg_d    = chg_q;
    digits_d = digits_q;
    if (start_i) begin
      busy_d   = 1'b1;
      dig_d    = '0;
      slot_d   = SlotClear;
      x_d      = CoordW'(cfg_i.margin);
      digits_d = new_dig;
      for (int k = 0; k < NumDigits; k++) begin
        chg_d[k] = shown_q[k] != new_dig[k];
      end
    end else if (busy_q && adv_i) begin
      slot_d = slot_e'(slot_q + 3'd1);
      if (slot_q == SlotLowRight) begin
        // advance to the next box: x moves on by the box width and the gap
        dig_d = dig_nxt;
        x_d   = x_q + CoordW'(cfg_i.digit_width) + CoordW'(gap);
        if (dig_q == DigIdxW'(NumDigits - 1)) busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      for (int k = 0; k < NumDigits; k++) shown_q[k] <= DigitBlank;
    end else begin
      busy_q <= busy_d;
      if (start_i) shown_q <= new_dig;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q    <= dig_d;
    slot_q   <= slot_d;
    x_q      <= x_d;
    chg_q    <= chg_d;
    digits_q <= digits_d;
  end

  assign step_o.busy = busy_q;
  assign step_o.emit = emit;
  assign step_o.last = !more_slot && !more_dig;
  assign step_o.slot = slot_q;
  assign step_o.x    = x_q;

endmodule

// ===== rtl/core/seven_segment_clock_rect_renderer.sv =====
// Top level of the seven-segment clock renderer: config registers, sequencer, output register.
// Sequencing: the first rectangle of an update passes through the sequencer registers and
//   then the output register before it reaches the master side. One update walks the slot
//   sequencer through 6 digit boxes x 8 slots, one slot per cycle while the master side does
//   not stall a rectangle. The input side is not ready while the sequencer runs, so a new
//   update is taken only after the previous one has walked all its slots.
// Reset: all seven configuration registers return to their defaults and every kept digit
//   reads blank, so the first update redraws all six boxes.
module seven_segment_clock_rect_renderer
  import sscr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // time update stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // hours[6:0], minutes[13:7], seconds[20:14], zero
  // rectangle command stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,  // left[11:0], top[23:12], right[35:24],
                                             // bottom[47:36], fill_color[63:48]
  output logic                m_axis_tlast
);

  cfg_t  cfg_q;
  step_t step;
  rect_t rect;
  rect_t out_q;
  logic  out_vld_q, out_last_q;
  logic  start, adv;

  // Configuration: take writes at any index, drop those beyond the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{MarginRst, DigitGapRst, ColonGapRst, DigitWidRst, LineWidRst,
                 FgColorRst, BgColorRst};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMargin:   cfg_q.margin      <= cfg_wdata_i[SizeW-1:0];
        CfgDigitGap: cfg_q.digit_gap   <= cfg_wdata_i[SizeW-1:0];
        CfgColonGap: cfg_q.colon_gap   <= cfg_wdata_i[SizeW-1:0];
        CfgDigitWid: cfg_q.digit_width <= cfg_wdata_i[SizeW-1:0];
        CfgLineWid:  cfg_q.line_width  <= cfg_wdata_i[LineW-1:0];
        CfgFgColor:  cfg_q.fg_color    <= cfg_wdata_i;
        CfgBgColor:  cfg_q.bg_color    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Accept a new update only while the sequencer is idle
  assign s_axis_tready = !step.busy;
  assign start         = s_axis_tvalid && s_axis_tready;
  // The sequencer moves on whenever the output register is free or being drained
  assign adv           = !out_vld_q || m_axis_tready;

  sscr_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .hours_i   (s_axis_tdata[6:0]),
    .minutes_i (s_axis_tdata[13:7]),
    .seconds_i (s_axis_tdata[20:14]),
    .cfg_i     (cfg_q),
    .adv_i     (adv),
    .step_o    (step)
  );

  sscr_geom u_geom (
    .cfg_i  (cfg_q),
    .step_i (step),
    .rect_o (rect)
  );

  // Output register: hold the rectangle until its transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= step.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && step.emit) begin
      out_q      <= rect;
      out_last_q <= step.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.color, out_q.bottom, out_q.right, out_q.top, out_q.left};
  assign m_axis_tlast  = out_last_q;

  // An accepted update always starts the sequencer
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> step.busy)
    else $error("sequencer idle after an accepted update");

  // Hold the sequencer while its rectangle cannot enter the output register
  a_emit_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.emit && !adv |=> $stable(step.slot) && $stable(step.x))
    else $error("sequencer moved on while its rectangle was stalled");

  // Nothing is produced while the sequencer is idle
  a_idle_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step.busy |-> !step.emit)
    else $error("rectangle emitted while idle");

endmodule

// ===== dv/seven_segment_clock_rect_renderer_tb.sv =====
// Self-checking testbench for the seven-segment clock rectangle renderer.
module seven_segment_clock_rect_renderer_tb
  import sscr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  ClkHalf     = 2;
  localparam int  ResetCycles = 10;
  // one update keeps the sequencer busy for 48 slots; allow a little more
  localparam int  SettleCycles = 64;
  localparam int  RandPhases   = 6;
  localparam int  RandItems    = 48;
  localparam int  MaxPrinted   = 30;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  // glyphs 0..9, upper-left in bit 7 down to lower-right in bit 1
  localparam logic [79:0] SegGlyphs = {8'hF2, 8'hFE, 8'h62, 8'hDE, 8'hD6,
                                       8'hB2, 8'h76, 8'h7C, 8'h22, 8'hEE};

  typedef struct packed {
    logic [ValW-1:0] hrs;
    logic [ValW-1:0] mins;
    logic [ValW-1:0] secs;
    logic            drain;  // hold this update back until every rectangle has come
  } time_upd_t;

  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
    logic [ColorW-1:0] color;
    logic              last;
  } fill_cmd_t;

  typedef enum logic [1:0] {SinkOpen, SinkCoin, SinkChoked, SinkLight} sink_mode_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [63:0]         m_axis_tdata;
  logic                m_axis_tlast;

  seven_segment_clock_rect_renderer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Mirror of the block: register file and the digits currently on the panel
  logic [SizeW-1:0]  margin_q      = MarginRst;
  logic [SizeW-1:0]  digit_gap_q   = DigitGapRst;
  logic [SizeW-1:0]  colon_gap_q   = ColonGapRst;
  logic [SizeW-1:0]  digit_width_q = DigitWidRst;
  logic [LineW-1:0]  line_width_q  = LineWidRst;
  logic [ColorW-1:0] fg_color_q    = FgColorRst;
  logic [ColorW-1:0] bg_color_q    = BgColorRst;
  logic [DigitW-1:0] shown_q [NumDigits];

  time_upd_t update_q [$];   // updates waiting to be offered
  fill_cmd_t fill_q [$];     // rectangles the block still owes us

  int mismatches    = 0;
  int updates_sent  = 0;
  int rects_seen    = 0;
  int settings_used = 1;

  initial begin
    forever #ClkHalf clk_i = ~clk_i;
  end

  // Hard stop if the block hangs or the traffic stalls for good
  initial begin
    #4_000_000;
    $display("[seven_segment_clock_rect_renderer] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("mismatch %0d at %0t: %s got 0x%0h expected 0x%0h",
               mismatches, $realtime, what, got, want);
  endtask

  function automatic fill_cmd_t mk_rect(input logic [CoordW-1:0] l, t, r, b,
                                        input logic [ColorW-1:0] c);
    fill_cmd_t f;
    f.left   = l;
    f.top    = t;
    f.right  = r;
    f.bottom = b;
    f.color  = c;
    f.last   = 1'b0;
    return f;
  endfunction

  // Work out the rectangles that one accepted update must produce, in order
  task automatic render_update(input logic [ValW-1:0] hrs, mins, secs);
    logic [DigitW-1:0] digit [NumDigits];
    logic [CoordW-1:0] x, y, xw, ym, y2;
    logic [CoordW-1:0] hl;
    logic [7:0]        pat;
    fill_cmd_t         cmds [$];
    fill_cmd_t         c;
    digit[0] = DigitW'(hrs / 7'd10);
    digit[1] = DigitW'(hrs % 7'd10);
    digit[2] = DigitW'(mins / 7'd10);
    digit[3] = DigitW'(mins % 7'd10);
    digit[4] = DigitW'(secs / 7'd10);
    digit[5] = DigitW'(secs % 7'd10);
    hl = CoordW'(line_width_q >> 1);
    x  = CoordW'(margin_q);
    y  = CoordW'(margin_q);
    for (int k = 0; k < NumDigits; k++) begin
      // advance past the previous box: digit gap inside a field, colon gap between fields
      if (k > 0) x = x + digit_width_q + ((k % 2 == 1) ? digit_gap_q : colon_gap_q);
      if (shown_q[k] != digit[k]) begin
        pat = (digit[k] < 4'd10) ? SegGlyphs[digit[k]*8 +: 8] : 8'h00;
        xw  = x + digit_width_q;
        ym  = y + digit_width_q;
        y2  = ym + digit_width_q;
        cmds.push_back(mk_rect(x, y, xw, y2, bg_color_q));
        for (int s = SlotUpLeft; s <= SlotLowRight; s++) begin
          if (pat[8-s]) begin
            case (slot_e'(s))
              SlotUpLeft:   cmds.push_back(mk_rect(x, y, x + line_width_q, ym, fg_color_q));
              SlotTop:      cmds.push_back(mk_rect(x, y, xw, y + line_width_q, fg_color_q));
              SlotUpRight:  cmds.push_back(mk_rect(xw - line_width_q, y, xw, ym, fg_color_q));
              SlotMiddle:   cmds.push_back(mk_rect(x, ym - hl, xw, ym + hl, fg_color_q));
              SlotLowLeft:  cmds.push_back(mk_rect(x, ym, x + line_width_q, y2, fg_color_q));
              SlotBottom:   cmds.push_back(mk_rect(x, y2 - line_width_q, xw, y2, fg_color_q));
              SlotLowRight: cmds.push_back(mk_rect(xw - line_width_q, ym, xw, y2, fg_color_q));
              default: ;
            endcase
          end
        end
        shown_q[k] = digit[k];
      end
    end
    // only the final rectangle of the update carries tlast
    for (int i = 0; i < cmds.size(); i++) begin
      c = cmds[i];
      c.last = (i == cmds.size() - 1);
      fill_q.push_back(c);
    end
  endtask

  // Sender: bursts of transfers separated by random gaps, fed from update_q
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : feed
    time_upd_t u;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        render_update(s_axis_tdata[6:0], s_axis_tdata[13:7], s_axis_tdata[20:14]);
        updates_sent++;
      end
      // the slot is free: either nothing offered or the offer just went through
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (update_q.size() > 0 && !(update_q[0].drain && fill_q.size() > 0)) begin
          u = update_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, u.secs, u.mins, u.hrs};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switch between stall patterns every so often
  sink_mode_e  sink_mode = SinkOpen;
  int unsigned sink_left = 0;

  always @(posedge clk_i) begin : sink
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(16, 160);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SinkOpen:   m_axis_tready <= 1'b1;
      SinkCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
      SinkChoked: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default:    m_axis_tready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // Monitor: every rectangle transfer is checked against the oldest expectation
  always @(posedge clk_i) begin : check
    fill_cmd_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rects_seen++;
      if (fill_q.size() == 0) begin
        report_mismatch("rectangle with nothing pending, tdata", m_axis_tdata, 0);
      end else begin
        want = fill_q.pop_front();
        if (m_axis_tdata[11:0] != want.left)
          report_mismatch("rect_left", m_axis_tdata[11:0], want.left);
        if (m_axis_tdata[23:12] != want.top)
          report_mismatch("rect_top", m_axis_tdata[23:12], want.top);
        if (m_axis_tdata[35:24] != want.right)
          report_mismatch("rect_right", m_axis_tdata[35:24], want.right);
        if (m_axis_tdata[47:36] != want.bottom)
          report_mismatch("rect_bottom", m_axis_tdata[47:36], want.bottom);
        if (m_axis_tdata[63:48] != want.color)
          report_mismatch("fill_color", m_axis_tdata[63:48], want.color);
        if (m_axis_tlast != want.last)
          report_mismatch("last", m_axis_tlast, want.last);
      end
    end
  end

  // Write one register and track it in the mirror; only called while idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgMargin:   margin_q      = val[SizeW-1:0];
      CfgDigitGap: digit_gap_q   = val[SizeW-1:0];
      CfgColonGap: colon_gap_q   = val[SizeW-1:0];
      CfgDigitWid: digit_width_q = val[SizeW-1:0];
      CfgLineWid:  line_width_q  = val[LineW-1:0];
      CfgFgColor:  fg_color_q    = val;
      CfgBgColor:  bg_color_q    = val;
      default: ;  // spare index: drop
    endcase
  endtask

  // Wait until every update went through and every rectangle came back,
  // then give a silent update time to leave the sequencer; sample between
  // edges so the sender's last offer has settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (update_q.size() > 0 || s_axis_tvalid || fill_q.size() > 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic queue_time(input int hrs, mins, secs, input bit drain = 1'b0);
    time_upd_t u;
    u.hrs   = ValW'(hrs);
    u.mins  = ValW'(mins);
    u.secs  = ValW'(secs);
    u.drain = drain;
    update_q.push_back(u);
  endtask

  // Mostly small register values; now and then a raw 16-bit word to exercise masking
  function automatic logic [CfgDataW-1:0] pick_reg(input int lo, hi);
    return ($urandom_range(0, 3) == 0) ? CfgDataW'($urandom) : CfgDataW'($urandom_range(lo, hi));
  endfunction

  initial begin : stimulus
    int th, tm, ts;
    for (int k = 0; k < NumDigits; k++) shown_q[k] = DigitBlank;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: full redraw from blank, repeats that draw nothing,
    // every glyph, values past 99 that show blank tens, single-digit changes
    queue_time(0, 0, 0);
    queue_time(0, 0, 0);
    queue_time(12, 34, 56);
    queue_time(78, 90, 19);
    queue_time(78, 90, 19, 1'b1);
    queue_time(23, 59, 59);
    queue_time(99, 99, 99);
    queue_time(127, 127, 127);
    queue_time(100, 110, 120);
    queue_time(88, 88, 88);
    queue_time(88, 88, 89);
    queue_time(127, 0, 85, 1'b1);
    queue_time(0, 0, 0);
    wait_idle();

    // Top of every range: coordinates stay below 4096, oversize data is masked
    write_reg(CfgMargin, 16'h00FF);
    write_reg(CfgDigitGap, 16'hFFFF);
    write_reg(CfgColonGap, 16'h00FF);
    write_reg(CfgDigitWid, 16'h00FF);
    write_reg(CfgLineWid, 16'hFFFF);
    write_reg(CfgFgColor, 16'hFFFF);
    write_reg(CfgBgColor, 16'hFFFF);
    write_reg(CfgIdxSpare, 16'h1234);
    settings_used++;
    queue_time(8, 88, 88);
    queue_time(1, 23, 45);
    queue_time(100, 0, 0);
    wait_idle();

    // Bottom of every range: zero box and zero stroke
    write_reg(CfgMargin, 16'h0000);
    write_reg(CfgDigitGap, 16'h0000);
    write_reg(CfgColonGap, 16'h0000);
    write_reg(CfgDigitWid, 16'h0000);
    write_reg(CfgLineWid, 16'h0000);
    write_reg(CfgFgColor, 16'h0000);
    write_reg(CfgBgColor, 16'h0000);
    settings_used++;
    queue_time(88, 88, 88);
    queue_time(12, 12, 12);
    wait_idle();

    // Stroke wider than the box: segment edges wrap below the box origin
    write_reg(CfgMargin, 16'h0003);
    write_reg(CfgDigitWid, 16'h0001);
    write_reg(CfgLineWid, 16'h003F);
    write_reg(CfgFgColor, 16'h07E0);
    write_reg(CfgBgColor, 16'h001F);
    settings_used++;
    queue_time(0, 0, 0);
    queue_time(68, 8, 48);
    queue_time(0, 0, 0);
    queue_time(1, 1, 1);
    wait_idle();

    // Random part: mostly a ticking clock, with repeats and wild values mixed in
    th = 1; tm = 1; ts = 1;
    for (int p = 0; p < RandPhases; p++) begin
      write_reg(CfgMargin, pick_reg(0, 40));
      write_reg(CfgDigitGap, pick_reg(0, 12));
      write_reg(CfgColonGap, pick_reg(0, 30));
      write_reg(CfgDigitWid, pick_reg(0, 40));
      write_reg(CfgLineWid, pick_reg(0, 8));
      write_reg(CfgFgColor, CfgDataW'($urandom));
      write_reg(CfgBgColor, CfgDataW'($urandom));
      if ($urandom_range(0, 1) == 0) write_reg(CfgIdxSpare, CfgDataW'($urandom));
      settings_used++;
      for (int i = 0; i < RandItems; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            // step the clock, carrying into minutes and hours
            ts += ($urandom_range(0, 5) == 0) ? $urandom_range(2, 61) : 1;
            if (ts >= 60) begin
              ts -= 60;
              tm++;
            end
            if (tm >= 60) begin
              tm = 0;
              th++;
            end
            if (th >= 24) th = 0;
          end
          5, 6: ;  // same time again
          default: begin
            th = $urandom_range(0, 127);
            tm = $urandom_range(0, 127);
            ts = $urandom_range(0, 127);
          end
        endcase
        queue_time(th, tm, ts, $urandom_range(0, 19) == 0);
      end
      wait_idle();
    end

    $display("covered %0d time updates under %0d register settings, %0d rectangles checked",
             updates_sent, settings_used, rects_seen);
    if (mismatches == 0) begin
      $display("[seven_segment_clock_rect_renderer] OK");
    end else begin
      $display("[seven_segment_clock_rect_renderer] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sscr_pkg.sv
rtl/core/sscr_geom.sv
rtl/core/sscr_seq.sv
rtl/core/seven_segment_clock_rect_renderer.sv
dv/seven_segment_clock_rect_renderer_tb.sv
